// ===== src/i2crpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register pointer bank package
// Shared operation codes, store layout and buffer tables.
// ----------------------------------------------------------------------------
package i2crpb_pkg;

  // Bus and host event codes.
  localparam logic [2:0] OP_ADDR_MATCH = 3'd0;
  localparam logic [2:0] OP_BYTE_RX    = 3'd1;
  localparam logic [2:0] OP_READ_REQ   = 3'd2;
  localparam logic [2:0] OP_STOP       = 3'd3;
  localparam logic [2:0] OP_HOST_WRITE = 3'd4;
  localparam logic [2:0] OP_HOST_READ  = 3'd5;
  localparam logic [2:0] OP_HOST_POP   = 3'd6;
  localparam logic [2:0] OP_NOP        = 3'd7;

  localparam int QUEUE_DEPTH = 8;

  localparam int STORE_SIZE = 28;
  localparam logic [4:0] STORE_LAST  = 5'd27;
  localparam logic [7:0] REG_COUNT   = 8'd21;
  localparam logic [4:0] READ_REGS   = 5'd5;
  localparam logic [4:0] REG_RANDOM  = 5'd3;
  localparam logic [4:0] REG_AUTH    = 5'd4;
  localparam logic [3:0] WRITE_LEN   = 4'd8;
  localparam logic [4:0] STATUS_ADDR = 5'd3;

  // Start address of the read buffer of registers 0..4.
  function automatic logic [4:0] read_base(input logic [2:0] r);
    logic [4:0] b;
    case (r)
      3'd0: b = 5'd0;
      3'd1: b = 5'd2;
      3'd2: b = 5'd3;
      3'd3: b = 5'd12;
      3'd4: b = 5'd20;
      default: b = 5'd0;
    endcase
    return b;
  endfunction

  // Length of the read buffer of registers 0..4.
  function automatic logic [3:0] read_len(input logic [2:0] r);
    logic [3:0] n;
    case (r)
      3'd0: n = 4'd2;
      3'd1: n = 4'd1;
      3'd2: n = 4'd1;
      3'd3: n = 4'd8;
      3'd4: n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // Start address of the random (0) and auth (1) write buffers.
  function automatic logic [4:0] write_base(input logic w);
    return w ? 5'd20 : 5'd4;
  endfunction

endpackage

// ===== src/i2c_slave_register_pointer_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave register pointer bank
// Register bank behind a byte-level I2C slave controller, with host access.
// ----------------------------------------------------------------------------
// Each input word is one event: a bus event reported by the byte-level I2C
// controller (address match, byte received, read request, stop), a host
// access to the 28-byte store (write, read) or a pop of the write-notice
// queue. Every word yields exactly one result word, registered when it is
// accepted. The block takes one word per clock cycle for as long as the
// result side keeps up: the result register frees itself in the same cycle
// as its word is taken, so s_tready stays high under back-to-back traffic.
// That figure is set by the single read port of the byte store and of the
// notice queue, whose registered read data forms the result word. The
// status byte (store address 3) lives in a register of its own so that
// the busy bit can be set on stop without a read-modify-write of the store.
// The notice queue holds at most QUEUE_DEPTH-1 notices; a stop that finds
// it full loses its notice. After reset the store reads as zero entry by
// entry until written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module i2c_slave_register_pointer_bank #(
  parameter int QUEUE_DEPTH = i2crpb_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: operation[2:0], data_byte[10:3], host_address[15:11].
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: tx_byte[7:0], host_byte[15:8], popped_register[20:16],
  // popped_valid[21], zero fill[23:22].
  output logic [23:0] m_tdata
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [2:0] operation;
  logic [7:0] data_byte;
  logic [4:0] host_address;
  logic       accept;

  assign operation    = s_tdata[2:0];
  assign data_byte    = s_tdata[10:3];
  assign host_address = s_tdata[15:11];

  // Store, with one valid bit per entry so unwritten entries read as zero.
  logic [7:0]            byte_store [0:i2crpb_pkg::STORE_SIZE-1];
  logic [i2crpb_pkg::STORE_SIZE-1:0] store_valid;
  logic [7:0]            status;

  logic [3:0]            read_cursors [0:4];
  logic [3:0]            write_fill_counts [0:1];
  logic [4:0]            selected_register;
  logic                  selection_valid;

  logic [4:0]            notice_queue [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0]      queue_write_pointer;
  logic [PTR_W-1:0]      queue_read_pointer;

  // Result register.
  logic                  out_valid;
  logic [7:0]            rd_data;
  logic                  rd_valid;
  logic                  rd_status;
  logic [7:0]            status_copy;
  logic                  tx_sel;
  logic                  hb_sel;
  logic [4:0]            pop_data;
  logic                  pop_valid;

  // Decode of the current event.
  logic                  sel_is_read;
  logic                  sel_is_write;
  logic [2:0]            ridx;
  logic                  widx;
  logic [3:0]            cursor;
  logic [3:0]            fill;
  logic [4:0]            tx_addr;
  logic                  tx_ok;
  logic                  host_ok;
  logic [4:0]            rd_addr;
  logic                  store_we;
  logic [4:0]            store_waddr;
  logic                  rx_fill;
  logic                  stop_notice;
  logic                  queue_full;
  logic                  queue_empty;
  logic [PTR_W-1:0]      wp_next;
  logic [PTR_W-1:0]      rp_next;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    sel_is_read  = selected_register < i2crpb_pkg::READ_REGS;
    sel_is_write = (selected_register == i2crpb_pkg::REG_RANDOM) ||
                   (selected_register == i2crpb_pkg::REG_AUTH);
    ridx   = selected_register[2:0];
    widx   = (selected_register == i2crpb_pkg::REG_AUTH);
    cursor = read_cursors[ridx];
    fill   = write_fill_counts[widx];

    tx_addr = 5'(i2crpb_pkg::read_base(ridx) + 5'(cursor));
    tx_ok   = (operation == i2crpb_pkg::OP_READ_REQ) && selection_valid &&
              sel_is_read && (cursor < i2crpb_pkg::read_len(ridx));
    host_ok = (operation == i2crpb_pkg::OP_HOST_READ) &&
              (host_address <= i2crpb_pkg::STORE_LAST);
    rd_addr = (operation == i2crpb_pkg::OP_HOST_READ) ? host_address : tx_addr;

    rx_fill = (operation == i2crpb_pkg::OP_BYTE_RX) && selection_valid &&
              sel_is_write && (fill < i2crpb_pkg::WRITE_LEN);

    store_we    = 1'b0;
    store_waddr = host_address;
    if (rx_fill) begin
      store_we    = 1'b1;
      store_waddr = 5'(i2crpb_pkg::write_base(widx) + 5'(fill));
    end else if ((operation == i2crpb_pkg::OP_HOST_WRITE) &&
                 (host_address <= i2crpb_pkg::STORE_LAST) &&
                 (host_address != i2crpb_pkg::STATUS_ADDR)) begin
      store_we = 1'b1;
    end

    wp_next = (queue_write_pointer == PTR_LAST) ? '0 :
              PTR_W'(queue_write_pointer + 1'b1);
    rp_next = (queue_read_pointer == PTR_LAST) ? '0 :
              PTR_W'(queue_read_pointer + 1'b1);
    queue_full  = (wp_next == queue_read_pointer);
    queue_empty = (queue_read_pointer == queue_write_pointer);

    stop_notice = (operation == i2crpb_pkg::OP_STOP) && selection_valid &&
                  sel_is_write && (fill != 4'd0);
  end

  // Store and queue arrays: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (store_we) begin
        byte_store[store_waddr] <= data_byte;
      end
      rd_data  <= byte_store[rd_addr];
      pop_data <= notice_queue[queue_read_pointer];
      if (stop_notice && !queue_full) begin
        notice_queue[queue_write_pointer] <= selected_register;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      store_valid         <= '0;
      status              <= 8'd0;
      for (int i = 0; i < 5; i++) begin
        read_cursors[i] <= 4'd0;
      end
      write_fill_counts[0] <= 4'd0;
      write_fill_counts[1] <= 4'd0;
      selected_register   <= 5'd0;
      selection_valid     <= 1'b0;
      queue_write_pointer <= '0;
      queue_read_pointer  <= '0;
    end else if (accept) begin
      if (store_we) begin
        store_valid[store_waddr] <= 1'b1;
      end
      case (operation)
        i2crpb_pkg::OP_ADDR_MATCH: begin
          selection_valid <= 1'b0;
        end
        i2crpb_pkg::OP_BYTE_RX: begin
          if (!selection_valid) begin
            // The first byte after an address match is the register pointer.
            if (data_byte < i2crpb_pkg::REG_COUNT) begin
              selected_register <= data_byte[4:0];
              selection_valid   <= 1'b1;
              if (data_byte[4:0] < i2crpb_pkg::READ_REGS) begin
                read_cursors[data_byte[2:0]] <= 4'd0;
              end
              if (data_byte[4:0] == i2crpb_pkg::REG_RANDOM) begin
                write_fill_counts[0] <= 4'd0;
              end
              if (data_byte[4:0] == i2crpb_pkg::REG_AUTH) begin
                write_fill_counts[1] <= 4'd0;
              end
            end
          end else if (rx_fill) begin
            write_fill_counts[widx] <= 4'(fill + 1'b1);
          end
        end
        i2crpb_pkg::OP_READ_REQ: begin
          if (tx_ok) begin
            read_cursors[ridx] <= 4'(cursor + 1'b1);
          end
        end
        i2crpb_pkg::OP_STOP: begin
          if (stop_notice) begin
            if (selected_register == i2crpb_pkg::REG_RANDOM) begin
              status[0] <= 1'b1;
            end
            if (!queue_full) begin
              queue_write_pointer <= wp_next;
            end
          end
        end
        i2crpb_pkg::OP_HOST_WRITE: begin
          if (host_address == i2crpb_pkg::STATUS_ADDR) begin
            status <= data_byte;
          end
        end
        i2crpb_pkg::OP_HOST_POP: begin
          if (!queue_empty) begin
            queue_read_pointer <= rp_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result word flags; the payload parts above need no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      tx_sel    <= 1'b0;
      hb_sel    <= 1'b0;
      pop_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
      tx_sel    <= tx_ok;
      hb_sel    <= host_ok;
      pop_valid <= (operation == i2crpb_pkg::OP_HOST_POP) && !queue_empty;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_valid    <= store_valid[rd_addr];
      rd_status   <= (rd_addr == i2crpb_pkg::STATUS_ADDR);
      status_copy <= status;
    end
  end

  logic [7:0] rd_byte;

  always_comb begin
    if (rd_status) begin
      rd_byte = status_copy;
    end else if (rd_valid) begin
      rd_byte = rd_data;
    end else begin
      rd_byte = 8'd0;
    end
  end

  assign m_tvalid       = out_valid;
  assign m_tdata[7:0]   = tx_sel ? rd_byte : 8'd0;
  assign m_tdata[15:8]  = hb_sel ? rd_byte : 8'd0;
  assign m_tdata[20:16] = pop_valid ? pop_data : 5'd0;
  assign m_tdata[21]    = pop_valid;
  assign m_tdata[23:22] = 2'b00;

endmodule
